@@ rtl/core/sgmpc_pkg.sv @@
package sgmpc_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int VALUE_BITS = 16;

    localparam int IN_W      = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 26;
    localparam int CNT_W     = 32;

    localparam int VAL_W = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             odd_row;
        logic             last_row;
        logic             final_cell;
        logic             has_left;
        logic             has_right;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

    // Turns a written count into the index of the last row or column in use.
    function automatic int cfg_last(input logic [CFG_W-1:0] v, input int maxv);
        int x;
        x = int'(v);
        if (x == 0) begin
            x = 1;
        end
        if (x > maxv) begin
            x = maxv;
        end
        return x - 1;
    endfunction

endpackage

@@ rtl/core/staggered_grid_max_path_count.sv @@
// Best top-to-bottom path sum over a honeycomb grid, with the number of paths
// that reach it. Cells enter one per cycle in row-major order; each request
// reads two entries of a line buffer that holds the previous row (two read
// ports, one write port) and writes the new entry back from the registered
// request stage, with write-to-read forwarding covering rows of one or two
// cells. The sustained rate is one cell per cycle. The result enters the
// output register when the stage holding the last cell of the grid fires and
// is held until taken; the input stalls only when the last cell of a following
// grid arrives while that result is still waiting. Counts saturate at 2^32-1
// and set count_saturated. Writing row_count or col_count, allowed only while
// idle, starts a new grid; the line buffer needs no clearing after reset.
module staggered_grid_max_path_count
    import sgmpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [IN_W-1:0]      i_cell_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SUM_W-1:0]     o_best_sum,
    output logic [CNT_W-1:0]     o_best_count,
    output logic                 o_count_saturated
);

    logic             accept;
    logic             s1_fire;
    logic             s1_valid;
    t_cell_ctl        s1;
    logic [COL_W-1:0] raddr_a;
    logic [COL_W-1:0] raddr_b;
    t_entry           rdata_a;
    t_entry           rdata_b;
    logic             we;
    logic [COL_W-1:0] waddr;
    t_entry           wdata;

    sgmpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_cell_value (i_cell_value),
        .i_s1_fire    (s1_fire),
        .o_in_stall   (o_in_stall),
        .o_accept     (accept),
        .o_raddr_a    (raddr_a),
        .o_raddr_b    (raddr_b),
        .o_s1_valid   (s1_valid),
        .o_s1         (s1)
    );

    sgmpc_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (accept),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    sgmpc_combine u_combine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clear           (i_cfg_we),
        .i_s1_valid        (s1_valid),
        .i_s1              (s1),
        .i_rdata_a         (rdata_a),
        .i_rdata_b         (rdata_b),
        .i_out_stall       (i_out_stall),
        .o_s1_fire         (s1_fire),
        .o_we              (we),
        .o_waddr           (waddr),
        .o_wdata           (wdata),
        .o_out_valid       (o_out_valid),
        .o_best_sum        (o_best_sum),
        .o_best_count      (o_best_count),
        .o_count_saturated (o_count_saturated)
    );

endmodule

@@ rtl/core/sgmpc_linebuf.sv @@
module sgmpc_linebuf
    import sgmpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [COL_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re,
    input  logic [COL_W-1:0] i_raddr_a,
    input  logic [COL_W-1:0] i_raddr_b,
    output t_entry           o_rdata_a,
    output t_entry           o_rdata_b
);

    t_entry r_mem [MAX_COLS];
    t_entry r_rdata_a;
    t_entry r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A read that meets a write to the same entry returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
            r_rdata_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/sgmpc_front.sv @@
module sgmpc_front
    import sgmpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic [IN_W-1:0]      i_cell_value,
    input  logic                 i_s1_fire,
    output logic                 o_in_stall,
    output logic                 o_accept,
    output logic [COL_W-1:0]     o_raddr_a,
    output logic [COL_W-1:0]     o_raddr_b,
    output logic                 o_s1_valid,
    output t_cell_ctl            o_s1
);

    logic [ROW_W-1:0] r_last_row;
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_s1_valid;
    t_cell_ctl        r_s1;
    t_cell_ctl        n_s1;
    logic             at_last_col;
    logic             at_last_row;

    assign o_in_stall  = r_s1_valid & ~i_s1_fire;
    assign o_accept    = i_in_valid & ~o_in_stall;
    assign at_last_col = (r_col == r_last_col);
    assign at_last_row = (r_row == r_last_row);
    assign o_raddr_a   = r_col;
    assign o_raddr_b   = r_col + COL_W'(1);

    always_comb begin
        n_s1.col        = r_col;
        n_s1.first_row  = (r_row == '0);
        n_s1.odd_row    = r_row[0];
        n_s1.last_row   = at_last_row;
        n_s1.final_cell = at_last_row & at_last_col;
        n_s1.has_left   = (r_col != '0);
        n_s1.has_right  = ~at_last_col;
        n_s1.value      = i_cell_value[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= '0;
            r_last_col <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROW_COUNT: r_last_row <= ROW_W'(cfg_last(i_cfg_data, MAX_ROWS));
                    REG_COL_COUNT: r_last_col <= COL_W'(cfg_last(i_cfg_data, MAX_COLS));
                endcase
                r_row <= '0;
                r_col <= '0;
            end else if (o_accept) begin
                if (at_last_col) begin
                    r_col <= '0;
                    r_row <= at_last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (o_accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

@@ rtl/core/sgmpc_combine.sv @@
module sgmpc_combine
    import sgmpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_s1_valid,
    input  t_cell_ctl        i_s1,
    input  t_entry           i_rdata_a,
    input  t_entry           i_rdata_b,
    input  logic             i_out_stall,
    output logic             o_s1_fire,
    output logic             o_we,
    output logic [COL_W-1:0] o_waddr,
    output t_entry           o_wdata,
    output logic             o_out_valid,
    output logic [SUM_W-1:0] o_best_sum,
    output logic [CNT_W-1:0] o_best_count,
    output logic             o_count_saturated
);

    t_entry           r_held;
    logic [SUM_W-1:0] r_run_best;
    logic [CNT_W-1:0] r_run_cnt;
    logic             r_sat;
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_sat;

    t_entry           nb_a;
    t_entry           nb_b;
    logic [CNT_W:0]   tie_add;
    logic [SUM_W-1:0] pick_sum;
    logic [CNT_W-1:0] pick_cnt;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] cell_sum;
    logic [CNT_W-1:0] cell_cnt;
    logic             cell_sat;
    logic [CNT_W:0]   run_add;
    logic [SUM_W-1:0] n_run_best;
    logic [CNT_W-1:0] n_run_cnt;
    logic             run_sat;
    logic             n_sat;
    logic             blocked;

    assign blocked   = i_s1.final_cell & r_out_valid & i_out_stall;
    assign o_s1_fire = i_s1_valid & ~blocked;

    // A shifted row draws on the cells below and below-right; an unshifted
    // row draws on the old entry to the left and the one below.
    always_comb begin
        if (i_s1.odd_row) begin
            nb_a = i_rdata_a;
            nb_b = i_s1.has_right ? i_rdata_b : '0;
        end else begin
            nb_a = i_s1.has_left ? r_held : '0;
            nb_b = i_rdata_a;
        end
        tie_add  = {1'b0, nb_a.cnt} + {1'b0, nb_b.cnt};
        cell_sat = 1'b0;
        if (nb_a.sum == nb_b.sum) begin
            pick_sum = nb_a.sum;
            pick_cnt = tie_add[CNT_W] ? CNT_MAX : tie_add[CNT_W-1:0];
            cell_sat = tie_add[CNT_W];
        end else if (nb_a.sum > nb_b.sum) begin
            pick_sum = nb_a.sum;
            pick_cnt = nb_a.cnt;
        end else begin
            pick_sum = nb_b.sum;
            pick_cnt = nb_b.cnt;
        end
        sum_add = {1'b0, pick_sum} + (SUM_W+1)'(i_s1.value);
        if (i_s1.first_row) begin
            cell_sum = SUM_W'(i_s1.value);
            cell_cnt = CNT_W'(1);
            cell_sat = 1'b0;
        end else begin
            cell_sum = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            cell_cnt = pick_cnt;
        end
    end

    always_comb begin
        run_add    = {1'b0, r_run_cnt} + {1'b0, cell_cnt};
        n_run_best = r_run_best;
        n_run_cnt  = r_run_cnt;
        run_sat    = 1'b0;
        if (i_s1.last_row) begin
            if (cell_sum > r_run_best) begin
                n_run_best = cell_sum;
                n_run_cnt  = cell_cnt;
            end else if (cell_sum == r_run_best) begin
                n_run_cnt = run_add[CNT_W] ? CNT_MAX : run_add[CNT_W-1:0];
                run_sat   = run_add[CNT_W];
            end
        end
        n_sat = r_sat | cell_sat | run_sat;
    end

    assign o_we          = o_s1_fire;
    assign o_waddr       = i_s1.col;
    assign o_wdata.sum   = cell_sum;
    assign o_wdata.cnt   = cell_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_best  <= '0;
            r_run_cnt   <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_run_best <= '0;
                r_run_cnt  <= '0;
                r_sat      <= 1'b0;
            end else if (o_s1_fire) begin
                if (i_s1.final_cell) begin
                    r_run_best <= '0;
                    r_run_cnt  <= '0;
                    r_sat      <= 1'b0;
                end else begin
                    r_run_best <= n_run_best;
                    r_run_cnt  <= n_run_cnt;
                    r_sat      <= n_sat;
                end
            end
            if (o_s1_fire && i_s1.final_cell) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_fire) begin
            r_held <= i_rdata_a;
        end
        if (o_s1_fire && i_s1.final_cell) begin
            r_out_sum <= n_run_best;
            r_out_cnt <= n_run_cnt;
            r_out_sat <= n_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_best_sum        = r_out_sum;
    assign o_best_count      = r_out_cnt;
    assign o_count_saturated = r_out_sat;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import sgmpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             sat;
    } t_grid_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [IN_W-1:0]      i_cell_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [SUM_W-1:0]     o_best_sum;
    logic [CNT_W-1:0]     o_best_count;
    logic                 o_count_saturated;

    staggered_grid_max_path_count dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cell_value      (i_cell_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_best_sum        (o_best_sum),
        .o_best_count      (o_best_count),
        .o_count_saturated (o_count_saturated)
    );

    always #5 i_clk = ~i_clk;

    // Path DP state mirrored from the block.
    logic [SUM_W-1:0] line_sum [0:MAX_COLS];
    logic [CNT_W-1:0] line_cnt [0:MAX_COLS];
    logic [SUM_W-1:0] left_sum;
    logic [CNT_W-1:0] left_cnt;
    int               row_pos;
    int               col_pos;
    int               rows_used;
    int               cols_used;
    logic [SUM_W-1:0] best_so_far;
    logic [CNT_W-1:0] count_so_far;
    logic             sat_seen;

    t_grid_result grid_results_due [$];

    bit idle_en = 1'b1;
    int error_count = 0;
    int cells_taken = 0;
    int grids_done = 0;
    int saturated_grids = 0;
    int quiet_cycles = 0;

    task automatic clear_progress();
        left_sum = '0;
        left_cnt = '0;
        row_pos = 0;
        col_pos = 0;
        best_so_far = '0;
        count_so_far = '0;
        sat_seen = 1'b0;
    endtask

    task automatic add_counts(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b,
                              output logic [CNT_W-1:0] r);
        logic [CNT_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t[CNT_W]) begin
            sat_seen = 1'b1;
            r = CNT_MAX;
        end else begin
            r = t[CNT_W-1:0];
        end
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int v;
        v = int'(data);
        if (v == 0) begin
            v = 1;
        end
        if (idx == REG_ROW_COUNT) begin
            rows_used = (v > MAX_ROWS) ? MAX_ROWS : v;
        end else begin
            cols_used = (v > MAX_COLS) ? MAX_COLS : v;
        end
        clear_progress();
    endtask

    task automatic predict_cell(input logic [IN_W-1:0] value);
        int               c;
        logic [SUM_W-1:0] a_sum, b_sum, s;
        logic [CNT_W-1:0] a_cnt, b_cnt, k;
        logic [SUM_W:0]   wide;
        t_grid_result     r;
        c = col_pos;
        if (c >= cols_used) begin
            c = 0;
        end
        a_sum = '0;
        a_cnt = '0;
        b_sum = '0;
        b_cnt = '0;
        if (row_pos == 0) begin
            s = SUM_W'(value);
            k = 1;
        end else begin
            if (row_pos % 2 == 0) begin
                if (c > 0) begin
                    a_sum = left_sum;
                    a_cnt = left_cnt;
                end
                b_sum = line_sum[c];
                b_cnt = line_cnt[c];
            end else begin
                a_sum = line_sum[c];
                a_cnt = line_cnt[c];
                if (c + 1 < cols_used) begin
                    b_sum = line_sum[c + 1];
                    b_cnt = line_cnt[c + 1];
                end
            end
            if (a_sum == b_sum) begin
                add_counts(a_cnt, b_cnt, k);
                s = a_sum;
            end else if (a_sum > b_sum) begin
                k = a_cnt;
                s = a_sum;
            end else begin
                k = b_cnt;
                s = b_sum;
            end
            wide = {1'b0, s} + (SUM_W+1)'(value);
            s = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
        end
        left_sum = line_sum[c];
        left_cnt = line_cnt[c];
        line_sum[c] = s;
        line_cnt[c] = k;
        if (row_pos + 1 >= rows_used) begin
            if (s > best_so_far) begin
                best_so_far = s;
                count_so_far = k;
            end else if (s == best_so_far) begin
                add_counts(count_so_far, k, count_so_far);
            end
        end
        c++;
        if (c >= cols_used) begin
            c = 0;
            row_pos++;
            left_sum = '0;
            left_cnt = '0;
        end
        col_pos = c;
        if (row_pos >= rows_used) begin
            r.sum = best_so_far;
            r.cnt = count_so_far;
            r.sat = sat_seen;
            grid_results_due.push_back(r);
            clear_progress();
        end
    endtask

    always @(posedge i_clk) begin
        t_grid_result want;
        if (!i_rst_n) begin
            rows_used = 1;
            cols_used = 1;
            clear_progress();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (grid_results_due.size() == 0) begin
                    $display("%0t: result with no grid pending, got sum %0d count %0d sat %0d",
                             $time, o_best_sum, o_best_count, o_count_saturated);
                    error_count++;
                end else begin
                    want = grid_results_due.pop_front();
                    grids_done++;
                    if (want.sat) begin
                        saturated_grids++;
                    end
                    if (o_best_sum !== want.sum) begin
                        $display("%0t: best_sum expected %0d, got %0d",
                                 $time, want.sum, o_best_sum);
                        error_count++;
                    end
                    if (o_best_count !== want.cnt) begin
                        $display("%0t: best_count expected %0d, got %0d",
                                 $time, want.cnt, o_best_count);
                        error_count++;
                    end
                    if (o_count_saturated !== want.sat) begin
                        $display("%0t: count_saturated expected %0d, got %0d",
                                 $time, want.sat, o_count_saturated);
                        error_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                cells_taken++;
                predict_cell(i_cell_value);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= idle_en && ($urandom_range(0, 99) < 28);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_cell(input logic [IN_W-1:0] value);
        while (idle_en && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_value <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (grid_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input int rows, input int cols);
        write_reg(REG_ROW_COUNT, CFG_W'(rows));
        write_reg(REG_COL_COUNT, CFG_W'(cols));
    endtask

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            return $urandom_range(1, 4);
        end else if (roll < 9) begin
            return $urandom_range(5, 8);
        end
        return $urandom_range(9, 16);
    endfunction

    function automatic logic [IN_W-1:0] pick_value(input int mode, input logic [IN_W-1:0] base);
        case (mode)
            0: begin
                return IN_W'($urandom);
            end
            1: begin
                return IN_W'($urandom_range(0, 2));
            end
            2: begin
                return base;
            end
            default: begin
                return $urandom_range(0, 1) ? '1 : '0;
            end
        endcase
    endfunction

    task automatic test_single_cells();
        set_grid(1, 1);
        send_cell('0);
        send_cell('1);
        send_cell(16'hAAAA);
        send_cell(16'h5555);
        drain_results();
    endtask

    task automatic test_small_grids();
        int i;
        set_grid(3, 3);
        for (i = 1; i <= 9; i++) begin
            send_cell(IN_W'(i));
        end
        set_grid(4, 3);
        for (i = 0; i < 12; i++) begin
            send_cell(16'd7);
        end
        set_grid(2, 1);
        send_cell(16'd3);
        send_cell('1);
        drain_results();
    endtask

    task automatic test_abandoned_grid();
        int i;
        set_grid(3, 3);
        for (i = 0; i < 4; i++) begin
            send_cell(IN_W'($urandom));
        end
        write_reg(REG_COL_COUNT, CFG_W'(3));
        for (i = 0; i < 9; i++) begin
            send_cell(IN_W'($urandom_range(0, 3)));
        end
        drain_results();
    endtask

    task automatic test_count_saturation();
        int i;
        // All-zero cells tie everywhere, so path counts grow until they clip.
        set_grid(50, 2);
        for (i = 0; i < 100; i++) begin
            send_cell('0);
        end
        set_grid(2, 4);
        for (i = 0; i < 8; i++) begin
            send_cell('0);
        end
        drain_results();
    endtask

    task automatic test_back_to_back();
        int i;
        set_grid(1, 2);
        idle_en = 1'b0;
        for (i = 0; i < 25; i++) begin
            send_cell(IN_W'($urandom));
            send_cell(IN_W'($urandom_range(0, 1)));
        end
        drain_results();
        idle_en = 1'b1;
    endtask

    task automatic test_random_grids();
        int               cells, grids, rows, cols, cut, mode, i;
        logic [IN_W-1:0]  base;
        cells = 0;
        grids = 0;
        rows = 2;
        cols = 2;
        set_grid(rows, cols);
        while (cells < 220 || grids < 12) begin
            if ($urandom_range(0, 3) == 0) begin
                rows = pick_size();
                cols = pick_size();
                set_grid(rows, cols);
            end else if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
            mode = $urandom_range(0, 3);
            base = IN_W'($urandom);
            cut = rows * cols;
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(0, rows * cols - 1);
            end
            for (i = 0; i < cut; i++) begin
                send_cell(pick_value(mode, base));
            end
            cells += cut;
            if (cut < rows * cols) begin
                write_reg(REG_COL_COUNT, CFG_W'(cols));
            end else begin
                grids++;
            end
        end
        drain_results();
    endtask

    task automatic test_register_extremes();
        int i;
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, '0);
        send_cell(16'h1234);
        write_reg(REG_ROW_COUNT, '1);
        write_reg(REG_COL_COUNT, CFG_W'(1));
        for (i = 0; i < 16; i++) begin
            send_cell('1);
        end
        write_reg(REG_ROW_COUNT, CFG_W'(1));
        write_reg(REG_COL_COUNT, '1);
        for (i = 0; i < 8; i++) begin
            send_cell(IN_W'($urandom));
        end
        write_reg(REG_ROW_COUNT, CFG_W'(2));
        write_reg(REG_COL_COUNT, CFG_W'(60));
        for (i = 0; i < 120; i++) begin
            send_cell(IN_W'($urandom_range(0, 1)));
        end
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_cells();
        test_small_grids();
        test_abandoned_grid();
        test_count_saturation();
        test_back_to_back();
        test_random_grids();
        test_register_extremes();
        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d cells through %0d grids, %0d of them with saturated counts.",
                 cells_taken, grids_done, saturated_grids);
        $display("Grids ranged from one cell to rows of sixty, with zero and oversize counts.");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
